[hw/rtl/swm_pkg.sv]
// Shared types and constants of the sliding window median filter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package swm_pkg;

  localparam int WINDOW_MAX  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = SAMPLE_BITS + 1;
  localparam int CFG_BITS    = 6;
  localparam int IDX_BITS    = $clog2(WINDOW_MAX);

  localparam logic [CFG_BITS-1:0] WSIZE_RESET = CFG_BITS'(3);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [OUT_BITS-1:0]    median_t;
  typedef logic [CFG_BITS-1:0]           count_t;
  typedef logic [IDX_BITS-1:0]           idx_t;

  // What one cell shows its neighbours: stored value and its two compare flags
  typedef struct packed {
    sample_t val;
    logic    geq;  // at or above the slot of the sample being dropped
    logic    gts;  // strictly above the incoming sample
  } cell_link_t;

  // Edges of the row: nothing below cell 0, plus infinity above the top cell
  localparam cell_link_t LINK_LOW  = '{val: '0, geq: 1'b0, gts: 1'b0};
  localparam cell_link_t LINK_HIGH = '{val: '0, geq: 1'b1, gts: 1'b1};

  // Clamp a written window size into 1 .. WINDOW_MAX
  function automatic count_t eff_window(input logic [CFG_BITS-1:0] raw);
    count_t w;
    w = raw;
    if (raw == '0) begin
      w = count_t'(1);
    end else if (raw > count_t'(WINDOW_MAX)) begin
      w = count_t'(WINDOW_MAX);
    end
    return w;
  endfunction

endpackage

[hw/rtl/sliding_window_median.sv]
// Sliding window median filter: one signed sample in, doubled median out.
//
// Input channel: in_valid_i / in_stall_o with sample_i. A transaction is taken
// at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with median_doubled_o, the sum of
// the two middle values of the window (twice the middle value for odd sizes).
// Configuration: cfg_valid_i / cfg_ready_o with cfg_data_i, the window size;
// 0 reads as 1, anything above 32 as 32. A write empties the window.
// Throughput: one sample per clock while in_stall_o is low. The row of 32
// sorted cells drops the oldest value and inserts the new one in one update;
// the oldest value comes from the arrival ring, read ahead of the update.
// Order: the cells take an accepted sample, its result is marked pending, and
// it is loaded into the output register once that register is empty or its
// result is being taken; it is then held there until the output is taken.
// The first window_size - 1 samples after reset or a write give no result.
// Reset: window size 3, window empty; no clearing pass is needed.
// Stall: a result waits one stage behind the output register; when both are
// full and out_stall_i is high, in_stall_o rises until the output is taken.
// Depends on swm_pkg, swm_cell, swm_ring and swm_out.
`timescale 1ns / 1ps

module sliding_window_median import swm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sample_t             sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output median_t             median_doubled_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_BITS-1:0] cfg_data_i
);

  count_t w_q, fill_q, fill_d, limit, w_new;
  idx_t   ptr_q, ptr_d, mid_lo_q, mid_hi_q, wr_addr;
  logic   pend_q, pend_d;
  logic   full, accept, moved, result, cfg_fire;
  sample_t    oldest;
  cell_link_t links [WINDOW_MAX];
  sample_t    vals  [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] cell_valid;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign w_new       = eff_window(cfg_data_i);

  assign full       = (fill_q == w_q);
  assign moved      = pend_q & (~out_valid_o | ~out_stall_i);
  assign in_stall_o = pend_q & out_valid_o & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign limit      = full ? w_q : fill_q;
  assign wr_addr    = full ? ptr_q : fill_q[IDX_BITS-1:0];

  // Work out fill, ring pointer and whether this transaction yields a result
  always_comb begin
    fill_d = fill_q;
    ptr_d  = ptr_q;
    result = 1'b0;
    if (cfg_fire) begin
      fill_d = '0;
      ptr_d  = '0;
    end else if (accept) begin
      if (full) begin
        result = 1'b1;
        if (count_t'(ptr_q) + count_t'(1) >= w_q) begin
          ptr_d = '0;
        end else begin
          ptr_d = ptr_q + idx_t'(1);
        end
      end else begin
        fill_d = fill_q + count_t'(1);
        ptr_d  = '0;
        result = (fill_d == w_q);
      end
    end
    pend_d = result | (pend_q & ~moved);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q      <= WSIZE_RESET;
      mid_hi_q <= idx_t'(WSIZE_RESET >> 1);
      mid_lo_q <= idx_t'(WSIZE_RESET >> 1);
      fill_q   <= '0;
      ptr_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      if (cfg_fire) begin
        w_q      <= w_new;
        mid_hi_q <= idx_t'(w_new[CFG_BITS-1:1]);
        mid_lo_q <= w_new[0] ? idx_t'(w_new[CFG_BITS-1:1])
                             : idx_t'(w_new[CFG_BITS-1:1]) - idx_t'(1);
      end
      fill_q <= fill_d;
      ptr_q  <= ptr_d;
      pend_q <= pend_d;
    end
  end

  // Arrival ring, read one slot ahead for the value to drop
  swm_ring u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (accept),
    .wr_addr_i (wr_addr),
    .wr_data_i (sample_i),
    .rd_addr_i (ptr_d),
    .rd_data_o (oldest)
  );

  // Row of sorted cells
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    cell_link_t left, right;

    assign cell_valid[i] = (count_t'(i) < limit);
    assign vals[i]       = links[i].val;

    if (i == 0) begin : g_low
      assign left = LINK_LOW;
    end else begin : g_mid_l
      assign left = links[i-1];
    end
    if (i == WINDOW_MAX - 1) begin : g_high
      assign right = LINK_HIGH;
    end else begin : g_mid_r
      assign right = links[i+1];
    end

    swm_cell u_cell (
      .clk_i    (clk_i),
      .en_i     (accept),
      .sample_i (sample_i),
      .oldest_i (oldest),
      .full_i   (full),
      .valid_i  (cell_valid[i]),
      .left_i   (left),
      .right_i  (right),
      .link_o   (links[i])
    );
  end

  // Median tap and output register
  swm_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (moved),
    .vals_i   (vals),
    .mid_lo_i (mid_lo_q),
    .mid_hi_i (mid_hi_q),
    .stall_i  (out_stall_i),
    .valid_o  (out_valid_o),
    .median_o (median_doubled_o)
  );

endmodule

[hw/rtl/swm_cell.sv]
// One cell of the sorted row: holds a single window value.
// Depends on swm_pkg; its neighbours are other swm_cell instances or the row edges.
`timescale 1ns / 1ps

module swm_cell import swm_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  sample_t    sample_i,
  input  sample_t    oldest_i,
  input  logic       full_i,
  input  logic       valid_i,
  input  cell_link_t left_i,
  input  cell_link_t right_i,
  output cell_link_t link_o
);

  sample_t val_q, val_d;
  logic    geq, gts;

  // Compare with dropped (when full) and incoming sample; empty cells act as infinity
  assign geq = full_i & (~valid_i | (val_q >= oldest_i));
  assign gts = ~valid_i | (val_q > sample_i);

  assign link_o = '{val: val_q, geq: geq, gts: gts};

  // Pick from the right neighbour, self, left neighbour or the new sample
  always_comb begin
    if (geq && !right_i.gts) begin
      val_d = right_i.val;
    end else if ((left_i.geq && gts) || (!geq && !gts)) begin
      val_d = val_q;
    end else if (!left_i.geq && left_i.gts) begin
      val_d = left_i.val;
    end else begin
      val_d = sample_i;
    end
  end

  // Advance on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

endmodule

[hw/rtl/swm_ring.sv]
// Arrival-order store: samples by ring slot, with a registered read of the oldest.
// Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_ring import swm_pkg::*; (
  input  logic    clk_i,
  input  logic    wr_en_i,
  input  idx_t    wr_addr_i,
  input  sample_t wr_data_i,
  input  idx_t    rd_addr_i,
  output sample_t rd_data_o
);

  sample_t mem [WINDOW_MAX];
  sample_t rd_q;

  // Write the new sample into its slot
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read the next oldest; forward a sample written to the same slot
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_q <= wr_data_i;
    end else begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

[hw/rtl/swm_out.sv]
// Output stage: taps the middle cells, adds them and holds the result.
// Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_out import swm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  sample_t vals_i [WINDOW_MAX],
  input  idx_t    mid_lo_i,
  input  idx_t    mid_hi_i,
  input  logic    stall_i,
  output logic    valid_o,
  output median_t median_o
);

  logic    valid_q;
  median_t median_q;
  sample_t lo, hi;

  assign lo = vals_i[mid_lo_i];
  assign hi = vals_i[mid_hi_i];

  // Hold valid while stalled, raise it on load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Sum of the two middle values
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      median_q <= median_t'(lo) + median_t'(hi);
    end
  end

  assign valid_o  = valid_q;
  assign median_o = median_q;

endmodule

[hw/rtl/swm_checker.sv]
// Port-level checks of the sliding window median filter, bound to the top level.
// Depends on swm_pkg and sliding_window_median.
`timescale 1ns / 1ps

module swm_checker import swm_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input median_t             median_doubled_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(median_doubled_o))
    else $error("stalled result changed");

  // Stall the input only behind a full, stalled output
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A sum of two samples never reaches the largest odd value
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> median_doubled_o != median_t'((1 << SAMPLE_BITS) - 1))
    else $error("doubled median out of range");

  // Configuration is never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);
